FILE: design/msl_pkg.sv
// shared types, token kind codes and character tables for the music script lexer
// no dependencies; used by msl_scan, msl_queue and music_script_lexer_core
`default_nettype none

package msl_pkg;

   localparam int FIELD_BITS = 24;
   localparam logic [FIELD_BITS-1:0] FIELD_MAX = 24'hFFFFFF;
   localparam int KW_COUNT = 8;
   localparam int KW_MAX_LEN = 6;
   localparam int MAX_KIND = 36;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_IDENT   = 4'd1,
      MODE_NUM     = 4'd2,
      MODE_NUMDOT  = 4'd3,
      MODE_FRAC    = 4'd4,
      MODE_OPER    = 4'd5,
      MODE_COMMENT = 4'd6,
      MODE_STRING  = 4'd7
   } scan_mode_type;

   localparam logic [5:0] KIND_EOF      = 6'd0;
   localparam logic [5:0] KIND_ERROR    = 6'd1;
   localparam logic [5:0] KIND_IDENT    = 6'd2;
   localparam logic [5:0] KIND_NUMBER   = 6'd3;
   localparam logic [5:0] KIND_STR_BASE = 6'd4;
   localparam logic [5:0] KIND_COLON    = 6'd8;
   localparam logic [5:0] KIND_LPAREN   = 6'd9;
   localparam logic [5:0] KIND_RPAREN   = 6'd10;
   localparam logic [5:0] KIND_SEMI     = 6'd11;
   localparam logic [5:0] KIND_CARET    = 6'd12;
   localparam logic [5:0] KIND_COMMA    = 6'd13;
   localparam logic [5:0] KIND_DOT      = 6'd14;
   localparam logic [5:0] KIND_MINUS    = 6'd15;
   localparam logic [5:0] KIND_ARROW    = 6'd16;
   localparam logic [5:0] KIND_PLUS     = 6'd17;
   localparam logic [5:0] KIND_SLASH    = 6'd18;
   localparam logic [5:0] KIND_STAR     = 6'd19;
   localparam logic [5:0] KIND_DOLLAR   = 6'd20;
   localparam logic [5:0] KIND_BANG     = 6'd21;
   localparam logic [5:0] KIND_ASSIGN   = 6'd23;
   localparam logic [5:0] KIND_LESS     = 6'd25;
   localparam logic [5:0] KIND_GREATER  = 6'd27;
   localparam logic [5:0] KIND_KW_BASE  = 6'd29;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_UNTERM     = 2'd1;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

   // keyword text, first character in the top byte, padded with zeros
   localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
      "tuning", {"doze", 16'h0}, {"perk", 16'h0}, {"swap", 16'h0},
      {"shake", 8'h0}, "future", {"tempo", 8'h0}, {"shift", 8'h0}
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd6, 3'd4, 3'd4, 3'd4, 3'd5, 3'd6, 3'd5, 3'd5
   };

   typedef struct packed {
      logic [5:0]            kind;
      logic [FIELD_BITS-1:0] start;
      logic [FIELD_BITS-1:0] length;
      logic [FIELD_BITS-1:0] line;
      logic [1:0]            err;
      logic                  last;
   } tok_rec_type;

   // up to three records leave the scanner for one byte
   typedef struct packed {
      logic [1:0]            count;
      tok_rec_type [2:0]     recs;
   } push_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [5:0] single_kind(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         "-": k = KIND_MINUS;
         "!": k = KIND_BANG;
         "=": k = KIND_ASSIGN;
         "<": k = KIND_LESS;
         ">": k = KIND_GREATER;
         default: k = KIND_SLASH;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] close_char(input logic [1:0] d);
      logic [7:0] c;
      case (d)
         2'd0: c = "\"";
         2'd1: c = "|";
         2'd2: c = "}";
         default: c = "]";
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: design/msl_scan.sv
// front end: per-byte scanner state machine that classifies bytes into tokens
// depends on msl_pkg; pushes up to three token records per byte into msl_queue
`default_nettype none

module msl_scan #(
   parameter int POSITION_BITS = 24,
   parameter int KEYWORD_CHARS = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        text_byte,
   input  wire logic              end_of_text,
   output msl_pkg::push_type      push
);

   localparam int P  = POSITION_BITS;
   localparam int FW = $clog2(KEYWORD_CHARS + 1);
   localparam int IW = $clog2(KEYWORD_CHARS);

   msl_pkg::scan_mode_type mode_ff, mode_in;
   logic [P-1:0]   pos_ff, pos_in;
   logic [P-1:0]   tb_ff, tb_in;
   logic [23:0]    line_ff, line_in;
   logic [KEYWORD_CHARS-1:0][7:0] prefix_ff, prefix_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic           too_long_ff, too_long_in;
   logic [7:0]     pend_ff, pend_in;
   logic [1:0]     cd_ff, cd_in;

   msl_pkg::tok_rec_type [2:0] recs;
   logic [1:0]     n;
   logic           fresh;
   logic [P:0]     p_x, prev_x, tb_x, tb1_x;
   logic [23:0]    line_inc;
   logic [5:0]     word_kind;

   function automatic logic [23:0] clampw(input logic [P:0] v);
      logic [32:0] w;
      w = 33'(v);
      return (w > 33'(msl_pkg::FIELD_MAX)) ? msl_pkg::FIELD_MAX : w[23:0];
   endfunction

   function automatic logic [P:0] span(input logic [P:0] a, input logic [P:0] b);
      return (b > a) ? b - a : '0;
   endfunction

   function automatic msl_pkg::tok_rec_type mk(input logic [5:0] kind,
      input logic [P:0] start, input logic [P:0] len, input logic [1:0] err,
      input logic [23:0] line);
      msl_pkg::tok_rec_type r;
      r.kind   = kind;
      r.start  = clampw(start);
      r.length = clampw(len);
      r.line   = line;
      r.err    = err;
      r.last   = 1'b0;
      return r;
   endfunction

   assign p_x      = {1'b0, pos_ff};
   assign prev_x   = (pos_ff != '0) ? p_x - 1'b1 : '0;
   assign tb_x     = {1'b0, tb_ff};
   assign tb1_x    = tb_x + 1'b1;
   assign line_inc = (line_ff == msl_pkg::FIELD_MAX) ? line_ff : line_ff + 1'b1;

   // keyword lookup on the stored word prefix
   always_comb begin
      logic hit;
      word_kind = msl_pkg::KIND_IDENT;
      for (int k = 0; k < msl_pkg::KW_COUNT; k++) begin
         hit = !too_long_ff && (fill_ff == FW'(msl_pkg::KW_LEN[k]));
         for (int i = 0; i < msl_pkg::KW_MAX_LEN; i++) begin
            if (i < int'(msl_pkg::KW_LEN[k]) &&
                prefix_ff[i] != msl_pkg::KW_TEXT[k][47-8*i -: 8])
               hit = 1'b0;
         end
         if (hit)
            word_kind = msl_pkg::KIND_KW_BASE + 6'(k);
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      pos_in      = pos_ff;
      tb_in       = tb_ff;
      line_in     = line_ff;
      prefix_in   = prefix_ff;
      fill_in     = fill_ff;
      too_long_in = too_long_ff;
      pend_in     = pend_ff;
      cd_in       = cd_ff;
      recs        = '0;
      n           = 2'd0;
      fresh       = 1'b0;

      if (end_of_text) begin
         case (mode_ff)
            msl_pkg::MODE_IDENT: begin
               recs[n] = mk(word_kind, tb_x, span(tb_x, p_x), msl_pkg::ERR_NONE, line_ff);
               n = n + 1'b1;
            end
            msl_pkg::MODE_NUM, msl_pkg::MODE_FRAC: begin
               recs[n] = mk(msl_pkg::KIND_NUMBER, tb_x, span(tb_x, p_x),
                            msl_pkg::ERR_NONE, line_ff);
               n = n + 1'b1;
            end
            msl_pkg::MODE_NUMDOT: begin
               recs[n] = mk(msl_pkg::KIND_NUMBER, tb_x, span(tb_x, prev_x),
                            msl_pkg::ERR_NONE, line_ff);
               n = n + 1'b1;
               recs[n] = mk(msl_pkg::KIND_DOT, prev_x, (P+1)'(1), msl_pkg::ERR_NONE, line_ff);
               n = n + 1'b1;
            end
            msl_pkg::MODE_OPER: begin
               recs[n] = mk(msl_pkg::single_kind(pend_ff), tb_x, (P+1)'(1),
                            msl_pkg::ERR_NONE, line_ff);
               n = n + 1'b1;
            end
            msl_pkg::MODE_STRING: begin
               recs[n] = mk(msl_pkg::KIND_ERROR, tb1_x, span(tb1_x, p_x),
                            msl_pkg::ERR_UNTERM, line_ff);
               n = n + 1'b1;
            end
            default: ;
         endcase
         recs[n] = mk(msl_pkg::KIND_EOF, p_x, '0, msl_pkg::ERR_NONE, line_ff);
         n = n + 1'b1;
         // back to the state after reset for the next text
         mode_in     = msl_pkg::MODE_IDLE;
         pos_in      = '0;
         tb_in       = '0;
         line_in     = 24'd1;
         prefix_in   = '0;
         fill_in     = '0;
         too_long_in = 1'b0;
         pend_in     = '0;
         cd_in       = '0;
      end else begin
         case (mode_ff)
            msl_pkg::MODE_IDENT: begin
               if (msl_pkg::is_alpha(text_byte) || msl_pkg::is_digit(text_byte)) begin
                  if (fill_ff < FW'(KEYWORD_CHARS)) begin
                     prefix_in[fill_ff[IW-1:0]] = text_byte;
                     fill_in = fill_ff + 1'b1;
                  end else begin
                     too_long_in = 1'b1;
                  end
               end else begin
                  recs[n] = mk(word_kind, tb_x, span(tb_x, p_x), msl_pkg::ERR_NONE, line_ff);
                  n = n + 1'b1;
                  fresh = 1'b1;
               end
            end
            msl_pkg::MODE_NUM: begin
               if (text_byte == ".") begin
                  mode_in = msl_pkg::MODE_NUMDOT;
               end else if (!msl_pkg::is_digit(text_byte)) begin
                  recs[n] = mk(msl_pkg::KIND_NUMBER, tb_x, span(tb_x, p_x),
                               msl_pkg::ERR_NONE, line_ff);
                  n = n + 1'b1;
                  fresh = 1'b1;
               end
            end
            msl_pkg::MODE_NUMDOT: begin
               if (msl_pkg::is_digit(text_byte)) begin
                  mode_in = msl_pkg::MODE_FRAC;
               end else begin
                  recs[n] = mk(msl_pkg::KIND_NUMBER, tb_x, span(tb_x, prev_x),
                               msl_pkg::ERR_NONE, line_ff);
                  n = n + 1'b1;
                  recs[n] = mk(msl_pkg::KIND_DOT, prev_x, (P+1)'(1),
                               msl_pkg::ERR_NONE, line_ff);
                  n = n + 1'b1;
                  fresh = 1'b1;
               end
            end
            msl_pkg::MODE_FRAC: begin
               if (!msl_pkg::is_digit(text_byte)) begin
                  recs[n] = mk(msl_pkg::KIND_NUMBER, tb_x, span(tb_x, p_x),
                               msl_pkg::ERR_NONE, line_ff);
                  n = n + 1'b1;
                  fresh = 1'b1;
               end
            end
            msl_pkg::MODE_OPER: begin
               if (pend_ff == "-" && text_byte == ">") begin
                  recs[n] = mk(msl_pkg::KIND_ARROW, tb_x, (P+1)'(2),
                               msl_pkg::ERR_NONE, line_ff);
                  n = n + 1'b1;
                  mode_in = msl_pkg::MODE_IDLE;
               end else if (pend_ff == "/" && text_byte == "/") begin
                  mode_in = msl_pkg::MODE_COMMENT;
               end else if (pend_ff != "-" && pend_ff != "/" && text_byte == "=") begin
                  recs[n] = mk(msl_pkg::single_kind(pend_ff) + 6'd1, tb_x, (P+1)'(2),
                               msl_pkg::ERR_NONE, line_ff);
                  n = n + 1'b1;
                  mode_in = msl_pkg::MODE_IDLE;
               end else begin
                  recs[n] = mk(msl_pkg::single_kind(pend_ff), tb_x, (P+1)'(1),
                               msl_pkg::ERR_NONE, line_ff);
                  n = n + 1'b1;
                  fresh = 1'b1;
               end
            end
            msl_pkg::MODE_COMMENT: begin
               if (text_byte == "\n")
                  fresh = 1'b1;
            end
            msl_pkg::MODE_STRING: begin
               if (text_byte == msl_pkg::close_char(cd_ff)) begin
                  recs[n] = mk(msl_pkg::KIND_STR_BASE + {4'd0, cd_ff}, tb1_x,
                               span(tb1_x, p_x), msl_pkg::ERR_NONE, line_ff);
                  n = n + 1'b1;
                  mode_in = msl_pkg::MODE_IDLE;
               end else if (text_byte == "\n") begin
                  line_in = line_inc;
               end
            end
            default: fresh = 1'b1;
         endcase

         // the byte starts a new token (or is skipped)
         if (fresh) begin
            mode_in = msl_pkg::MODE_IDLE;
            case (text_byte) inside
               " ", "\r", "\t": ;
               "\n": line_in = line_inc;
               ":": begin recs[n] = mk(msl_pkg::KIND_COLON, p_x, (P+1)'(1),
                                       msl_pkg::ERR_NONE, line_ff); n = n + 1'b1; end
               "(": begin recs[n] = mk(msl_pkg::KIND_LPAREN, p_x, (P+1)'(1),
                                       msl_pkg::ERR_NONE, line_ff); n = n + 1'b1; end
               ")": begin recs[n] = mk(msl_pkg::KIND_RPAREN, p_x, (P+1)'(1),
                                       msl_pkg::ERR_NONE, line_ff); n = n + 1'b1; end
               ";": begin recs[n] = mk(msl_pkg::KIND_SEMI, p_x, (P+1)'(1),
                                       msl_pkg::ERR_NONE, line_ff); n = n + 1'b1; end
               "^": begin recs[n] = mk(msl_pkg::KIND_CARET, p_x, (P+1)'(1),
                                       msl_pkg::ERR_NONE, line_ff); n = n + 1'b1; end
               ",": begin recs[n] = mk(msl_pkg::KIND_COMMA, p_x, (P+1)'(1),
                                       msl_pkg::ERR_NONE, line_ff); n = n + 1'b1; end
               ".": begin recs[n] = mk(msl_pkg::KIND_DOT, p_x, (P+1)'(1),
                                       msl_pkg::ERR_NONE, line_ff); n = n + 1'b1; end
               "+": begin recs[n] = mk(msl_pkg::KIND_PLUS, p_x, (P+1)'(1),
                                       msl_pkg::ERR_NONE, line_ff); n = n + 1'b1; end
               "*": begin recs[n] = mk(msl_pkg::KIND_STAR, p_x, (P+1)'(1),
                                       msl_pkg::ERR_NONE, line_ff); n = n + 1'b1; end
               "$": begin recs[n] = mk(msl_pkg::KIND_DOLLAR, p_x, (P+1)'(1),
                                       msl_pkg::ERR_NONE, line_ff); n = n + 1'b1; end
               "-", "!", "=", "<", ">", "/": begin
                  mode_in = msl_pkg::MODE_OPER;
                  pend_in = text_byte;
                  tb_in   = pos_ff;
               end
               "\"": begin mode_in = msl_pkg::MODE_STRING; cd_in = 2'd0; tb_in = pos_ff; end
               "|":  begin mode_in = msl_pkg::MODE_STRING; cd_in = 2'd1; tb_in = pos_ff; end
               "{":  begin mode_in = msl_pkg::MODE_STRING; cd_in = 2'd2; tb_in = pos_ff; end
               "[":  begin mode_in = msl_pkg::MODE_STRING; cd_in = 2'd3; tb_in = pos_ff; end
               ["a":"z"], ["A":"Z"], "_": begin
                  mode_in      = msl_pkg::MODE_IDENT;
                  tb_in        = pos_ff;
                  prefix_in[0] = text_byte;
                  fill_in      = FW'(1);
                  too_long_in  = 1'b0;
               end
               ["0":"9"]: begin
                  mode_in = msl_pkg::MODE_NUM;
                  tb_in   = pos_ff;
               end
               default: begin
                  recs[n] = mk(msl_pkg::KIND_ERROR, p_x, (P+1)'(1),
                               msl_pkg::ERR_UNEXPECTED, line_ff);
                  n = n + 1'b1;
               end
            endcase
         end

         if (pos_ff != {P{1'b1}})
            pos_in = pos_ff + 1'b1;
      end

      if (n != 2'd0)
         recs[n - 1'b1].last = 1'b1;
   end

   assign push.count = accept ? n : 2'd0;
   assign push.recs  = recs;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= msl_pkg::MODE_IDLE;
         pos_ff      <= '0;
         tb_ff       <= '0;
         line_ff     <= 24'd1;
         prefix_ff   <= '0;
         fill_ff     <= '0;
         too_long_ff <= 1'b0;
         pend_ff     <= '0;
         cd_ff       <= '0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         pos_ff      <= pos_in;
         tb_ff       <= tb_in;
         line_ff     <= line_in;
         prefix_ff   <= prefix_in;
         fill_ff     <= fill_in;
         too_long_ff <= too_long_in;
         pend_ff     <= pend_in;
         cd_ff       <= cd_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/msl_queue.sv
// back end: 8-entry token queue, takes up to 3 records/cycle, one out if ready
// depends on msl_pkg; fed by msl_scan, drives the result channel
`default_nettype none

module msl_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire msl_pkg::push_type     push,
   output logic                       room,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output msl_pkg::tok_rec_type       out_rec
);

   localparam int DEPTH = 8;
   localparam int AW    = $clog2(DEPTH);

   msl_pkg::tok_rec_type mem [DEPTH];
   logic [AW-1:0] wr_ff, wr_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic [AW:0]   count_ff, count_in;
   logic          pop;

   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_rec   = mem[rd_ff];
   // room for the worst byte, whatever leaves this cycle
   assign room      = (count_ff <= (AW+1)'(DEPTH - 3));

   always_comb begin
      wr_in    = wr_ff + AW'(push.count);
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (AW+1)'(push.count) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < push.count)
            mem[wr_ff + AW'(i)] <= push.recs[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(DEPTH))
      else $error("token queue overflow");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("scanner pushed without room");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (!out_valid && push.count == 2'd0) |=> !out_valid)
      else $error("queue became non-empty without a push");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_rec.kind <= 6'(msl_pkg::MAX_KIND)))
      else $error("token kind out of range");
`endif

endmodule

`default_nettype wire

FILE: design/music_script_lexer_core.sv
// top level of the music script lexer: scanner front end and token queue back end
// depends on msl_pkg, msl_scan and msl_queue
//
// channel  dir  tdata                                   tuser                  tlast
// req_     in   [7:0] text_byte                         -                      end_of_text
// rsp_     out  [23:0] start [47:24] length [71:48] line [5:0] kind [7:6] error last_of_run
//
// one byte taken per cycle while there is room; the scanner updates its state in that cycle
// a byte yields zero to three tokens, queued and sent one per cycle while rsp_tready is high
// the byte input stalls while fewer than three queue entries are free
// reset is synchronous and leaves the scanner between tokens at offset 0, line 1
`default_nettype none

module music_script_lexer_core #(
   parameter int POSITION_BITS = 24,
   parameter int KEYWORD_CHARS = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_byte
   input  wire logic        req_tlast,   // end_of_text
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // [23:0] start_offset, [47:24] token_length,
                                         // [71:48] line_number
   output logic [7:0]       rsp_tuser,   // [5:0] token_kind, [7:6] error_code
   output logic             rsp_tlast    // last_of_run
);

   msl_pkg::push_type    push;
   msl_pkg::tok_rec_type head;
   logic                 room;

   assign req_tready = room;

   msl_scan #(
      .POSITION_BITS (POSITION_BITS),
      .KEYWORD_CHARS (KEYWORD_CHARS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_tvalid && room),
      .text_byte   (req_tdata),
      .end_of_text (req_tlast),
      .push        (push)
   );

   msl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (head)
   );

   assign rsp_tdata = {head.line, head.length, head.start};
   assign rsp_tuser = {head.err, head.kind};
   assign rsp_tlast = head.last;

endmodule

`default_nettype wire
